[rtl/sdtt_pkg.sv]
// Shared types and constants of the sorted date/time table.
`timescale 1ns / 1ps

package sdtt_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LIST   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [2:0] ST_INSERTED   = 3'd0;
   localparam logic [2:0] ST_BAD_DATE   = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_LIST_ENTRY = 3'd3;
   localparam logic [2:0] ST_LIST_EMPTY = 3'd4;
   localparam logic [2:0] ST_CLEARED    = 3'd5;

   localparam logic [3:0] MAX_MONTH = 4'd12;
   localparam logic [5:0] MAX_DAY   = 6'd31;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  month;
      logic [5:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  out_month;
      logic [5:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [31:0] out_payload;
      logic        last;
   } rsp_type;

   // Stored word: the key (month, day, hour, minute) sits above the payload
   typedef struct packed {
      logic [3:0]  month;
      logic [5:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [31:0] payload;
   } entry_type;

   localparam int KEY_BITS = 21;

   typedef struct packed {
      logic bad_date;
      logic full;
      logic empty;
   } dec_type;

endpackage

[rtl/sorted_date_time_table_unit.sv]
// Top level of the sorted date/time table: entry memory, insert shifter and lister.
// A rejected insert, a clear, an empty listing or an insert into an empty table answers
// in the cycle after acceptance; any other insert walks down from the top entry, moving
// each entry with a greater key up one place, then writes the new entry and answers.
// A list of n entries gives n results, one memory read per result.
// Throughput: busy drops as the final result is driven, so the next transaction is taken
// at the edge ending that result's cycle; the receiver cannot stall. Reset empties the table.
`timescale 1ns / 1ps

module sorted_date_time_table_unit #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sdtt_pkg::req_type req_data,
   output logic              rsp_valid,
   output sdtt_pkg::rsp_type rsp_data
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int KB = sdtt_pkg::KEY_BITS;

   // controller states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_PLACE = 2'd2;
   localparam logic [1:0] S_LIST  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW - 1:0]     count_ff, count_in;
   logic [AW - 1:0]     ptr_ff, ptr_in;
   sdtt_pkg::entry_type new_ff, new_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sdtt_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // entry memory: one write and one registered read per cycle
   sdtt_pkg::entry_type mem [TABLE_ENTRIES];
   sdtt_pkg::entry_type rd_data_ff;
   logic [AW - 1:0]     rd_addr;
   logic                wr_en;
   logic [AW - 1:0]     wr_addr;
   sdtt_pkg::entry_type wr_data;

   sdtt_pkg::dec_type   dec;
   sdtt_pkg::entry_type req_entry;
   logic                accept;
   logic                rd_greater;
   logic [AW - 1:0]     last_addr;
   logic [AW - 1:0]     ptr_next;
   logic [AW - 1:0]     ptr_prev;

   sdtt_decode #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_decode (
      .req  (req_data),
      .count(count_ff),
      .dec  (dec)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_entry  = '{month: req_data.month, day: req_data.day, hour: req_data.hour,
                         minute: req_data.minute, payload: req_data.payload};
   assign last_addr  = AW'(count_ff - CW'(1));
   assign ptr_next   = ptr_ff + AW'(1);
   assign ptr_prev   = ptr_ff - AW'(1);
   // stored key strictly above the new key: that entry moves up one place
   assign rd_greater = (rd_data_ff[$bits(sdtt_pkg::entry_type) - 1 -: KB] >
                        new_ff[$bits(sdtt_pkg::entry_type) - 1 -: KB]);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      new_in       = new_ff;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = new_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rsp_data_in.last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  sdtt_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (dec.bad_date) begin
                        rsp_data_in.status = sdtt_pkg::ST_BAD_DATE;
                     end else if (dec.full) begin
                        rsp_data_in.status = sdtt_pkg::ST_FULL;
                     end else if (dec.empty) begin
                        // nothing to shift: write straight into place 0
                        wr_en              = 1'b1;
                        wr_addr            = '0;
                        wr_data            = req_entry;
                        count_in           = count_ff + CW'(1);
                        rsp_data_in.status = sdtt_pkg::ST_INSERTED;
                     end else begin
                        // hold the answer; walk down from the top entry
                        rsp_valid_in = 1'b0;
                        new_in       = req_entry;
                        rd_addr      = last_addr;
                        ptr_in       = last_addr;
                        state_in     = S_SHIFT;
                     end
                  end
                  sdtt_pkg::OP_LIST: begin
                     if (dec.empty) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = sdtt_pkg::ST_LIST_EMPTY;
                     end else begin
                        rd_addr  = '0;
                        ptr_in   = '0;
                        state_in = S_LIST;
                     end
                  end
                  sdtt_pkg::OP_CLEAR: begin
                     count_in           = '0;
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.status = sdtt_pkg::ST_CLEARED;
                  end
                  default: begin
                     // unused operation: drop it silently
                  end
               endcase
            end
         end
         S_SHIFT: begin
            if (rd_greater) begin
               // move the entry up, then read the one below
               wr_en   = 1'b1;
               wr_addr = ptr_next;
               wr_data = rd_data_ff;
               if (ptr_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  rd_addr = ptr_prev;
                  ptr_in  = ptr_prev;
               end
            end else begin
               wr_en              = 1'b1;
               wr_addr            = ptr_next;
               wr_data            = new_ff;
               count_in           = count_ff + CW'(1);
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = sdtt_pkg::ST_INSERTED;
               state_in           = S_IDLE;
            end
         end
         S_PLACE: begin
            // every stored key was greater: new entry heads the table
            wr_en              = 1'b1;
            wr_addr            = '0;
            wr_data            = new_ff;
            count_in           = count_ff + CW'(1);
            rsp_valid_in       = 1'b1;
            rsp_data_in.status = sdtt_pkg::ST_INSERTED;
            state_in           = S_IDLE;
         end
         S_LIST: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.status     = sdtt_pkg::ST_LIST_ENTRY;
            rsp_data_in.out_month  = rd_data_ff.month;
            rsp_data_in.out_day    = rd_data_ff.day;
            rsp_data_in.out_hour   = rd_data_ff.hour;
            rsp_data_in.out_minute = rd_data_ff.minute;
            rsp_data_in.out_payload = rd_data_ff.payload;
            if (ptr_ff == last_addr) begin
               rsp_data_in.last = 1'b1;
               state_in         = S_IDLE;
            end else begin
               rsp_data_in.last = 1'b0;
               rd_addr          = ptr_next;
               ptr_in           = ptr_next;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff      <= new_in;
      rsp_data_ff <= rsp_data_in;
   end

   // the fill count never passes the table depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
   else $error("entry count above table depth");

   // a clear transaction empties the table on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == sdtt_pkg::OP_CLEAR) |=> (count_ff == '0))
   else $error("clear did not empty the table");

   // only list entries may carry a cleared last flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != sdtt_pkg::ST_LIST_ENTRY)
         |-> rsp_data_ff.last)
   else $error("single result without last flag");

   // a completed insert grows the table by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == sdtt_pkg::ST_INSERTED)
         |-> (count_ff == $past(count_ff) + CW'(1)))
   else $error("insert did not grow the table by one");

endmodule

[rtl/sdtt_decode.sv]
// Request checks of the sorted date/time table: date range, full and empty table.
`timescale 1ns / 1ps

module sdtt_decode #(
   parameter int TABLE_ENTRIES = 32
) (
   input  sdtt_pkg::req_type                      req,
   input  logic [$clog2(TABLE_ENTRIES + 1) - 1:0] count,
   output sdtt_pkg::dec_type                      dec
);

   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW - 1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   always_comb begin
      dec.bad_date = (req.month == 4'd0) || (req.month > sdtt_pkg::MAX_MONTH) ||
                     (req.day == 6'd0) || (req.day > sdtt_pkg::MAX_DAY);
      dec.full     = (count >= FULL_COUNT);
      dec.empty    = (count == '0);
   end

endmodule

[test/sorted_date_time_table_checker.sv]
// Checker for the sorted date/time table: shadow table, expected responses, comparison.
`timescale 1ns / 1ps

module sorted_date_time_table_checker #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  sdtt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  sdtt_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                outstanding,
   output int                results_seen
);

   sdtt_pkg::entry_type held_entries [TABLE_ENTRIES];
   int                  held;
   sdtt_pkg::rsp_type   due_responses [$];

   initial begin
      mismatches   = 0;
      outstanding  = 0;
      results_seen = 0;
      held         = 0;
   end

   // Every non-listing response carries zero entry fields and the last flag.
   function automatic sdtt_pkg::rsp_type plain_response(logic [2:0] status);
      sdtt_pkg::rsp_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic void sort_and_answer(sdtt_pkg::req_type item);
      sdtt_pkg::entry_type fresh;
      sdtt_pkg::rsp_type   r;
      int                  slot;
      int                  i;
      case (item.operation)
         sdtt_pkg::OP_INSERT: begin
            if (item.month == 0 || item.month > sdtt_pkg::MAX_MONTH ||
                item.day == 0 || item.day > sdtt_pkg::MAX_DAY) begin
               due_responses.push_back(plain_response(sdtt_pkg::ST_BAD_DATE));
            end else if (held >= TABLE_ENTRIES) begin
               due_responses.push_back(plain_response(sdtt_pkg::ST_FULL));
            end else begin
               fresh = {item.month, item.day, item.hour, item.minute, item.payload};
               // equal keys: the newcomer goes behind the existing ones
               slot = held;
               for (i = 0; i < held; i++) begin
                  if ({item.month, item.day, item.hour, item.minute} <
                      {held_entries[i].month, held_entries[i].day,
                       held_entries[i].hour, held_entries[i].minute}) begin
                     slot = i;
                     break;
                  end
               end
               for (i = held; i > slot; i--) held_entries[i] = held_entries[i - 1];
               held_entries[slot] = fresh;
               held++;
               due_responses.push_back(plain_response(sdtt_pkg::ST_INSERTED));
            end
         end
         sdtt_pkg::OP_LIST: begin
            if (held == 0) begin
               due_responses.push_back(plain_response(sdtt_pkg::ST_LIST_EMPTY));
            end else begin
               for (i = 0; i < held; i++) begin
                  r             = '0;
                  r.status      = sdtt_pkg::ST_LIST_ENTRY;
                  r.out_month   = held_entries[i].month;
                  r.out_day     = held_entries[i].day;
                  r.out_hour    = held_entries[i].hour;
                  r.out_minute  = held_entries[i].minute;
                  r.out_payload = held_entries[i].payload;
                  r.last        = (i == held - 1);
                  due_responses.push_back(r);
               end
            end
         end
         sdtt_pkg::OP_CLEAR: begin
            held = 0;
            due_responses.push_back(plain_response(sdtt_pkg::ST_CLEARED));
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : watch
      sdtt_pkg::rsp_type want;
      bit                wrong;
      if (reset) begin
         due_responses.delete();
         held = 0;
      end else begin
         // responses belong to older transactions, so compare before predicting
         if (rsp_valid) begin
            results_seen++;
            if (due_responses.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected response status=%0d last=%0b",
                           $realtime, rsp_data.status, rsp_data.last);
               mismatches++;
            end else begin
               want  = due_responses.pop_front();
               wrong = (want.status      !== rsp_data.status)     ||
                       (want.out_month   !== rsp_data.out_month)  ||
                       (want.out_day     !== rsp_data.out_day)    ||
                       (want.out_hour    !== rsp_data.out_hour)   ||
                       (want.out_minute  !== rsp_data.out_minute) ||
                       (want.out_payload !== rsp_data.out_payload)||
                       (want.last        !== rsp_data.last);
               if (wrong) begin
                  if (mismatches < 10) begin
                     $display("%0t: mismatch expected st=%0d %0d/%0d %0d:%0d pl=%h last=%0b",
                              $realtime, want.status, want.out_month, want.out_day,
                              want.out_hour, want.out_minute, want.out_payload, want.last);
                     $display("%0t:          got      st=%0d %0d/%0d %0d:%0d pl=%h last=%0b",
                              $realtime, rsp_data.status, rsp_data.out_month,
                              rsp_data.out_day, rsp_data.out_hour, rsp_data.out_minute,
                              rsp_data.out_payload, rsp_data.last);
                  end
                  mismatches++;
               end
            end
         end
         if (start && !busy) sort_and_answer(req_data);
      end
      outstanding = due_responses.size();
   end

endmodule

[test/sorted_date_time_table_unit_test.sv]
// Testbench top for the sorted date/time table: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module sorted_date_time_table_unit_test;

   localparam int         TABLE_ENTRIES = 32;
   localparam int         ITEM_TARGET   = 270;
   // operation code that the block ignores
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   sdtt_pkg::req_type req_data;
   logic              rsp_valid;
   sdtt_pkg::rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int results_seen;

   // transaction counts by kind, for the closing summary
   int n_insert;
   int n_list;
   int n_clear;
   int n_unused;
   int counted;
   int burst_left;

   sorted_date_time_table_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   sorted_date_time_table_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .results_seen(results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs or stops answering.
   initial begin
      #2ms;
      $display("sorted_date_time_table_unit regression: fail");
      $finish;
   end

   function automatic sdtt_pkg::req_type make_req(logic [1:0] op, logic [3:0] month,
                                                  logic [5:0] day, logic [4:0] hour,
                                                  logic [5:0] minute, logic [31:0] payload);
      sdtt_pkg::req_type r;
      r.operation = op;
      r.month     = month;
      r.day       = day;
      r.hour      = hour;
      r.minute    = minute;
      r.payload   = payload;
      return r;
   endfunction

   // Fields other than the operation are noise for listings and the like.
   function automatic sdtt_pkg::req_type noise_req(logic [1:0] op);
      return make_req(op, 4'($urandom), 6'($urandom), 5'($urandom), 6'($urandom),
                      $urandom);
   endfunction

   // Valid date; the narrow form crowds keys together to force ties and
   // neighbouring keys, the wide form spreads over all valid dates and the whole hour and minute fields.
   function automatic sdtt_pkg::req_type good_insert();
      if ($urandom_range(0, 1) == 0)
         return make_req(sdtt_pkg::OP_INSERT, 4'($urandom_range(1, 2)),
                         6'($urandom_range(1, 2)), 5'($urandom_range(0, 1)),
                         6'($urandom_range(0, 1)), $urandom);
      return make_req(sdtt_pkg::OP_INSERT, 4'($urandom_range(1, 12)),
                      6'($urandom_range(1, 31)), 5'($urandom_range(0, 31)),
                      6'($urandom_range(0, 63)), $urandom);
   endfunction

   // Date that must be refused: zero or oversized month, zero or oversized day.
   function automatic sdtt_pkg::req_type bad_insert();
      sdtt_pkg::req_type r;
      r = good_insert();
      case ($urandom_range(0, 3))
         0:       begin r.month = 4'd0;  r.day = 6'($urandom_range(0, 63)); end
         1:       r.month = 4'($urandom_range(13, 15));
         2:       r.day   = 6'd0;
         default: r.day   = 6'($urandom_range(32, 63));
      endcase
      return r;
   endfunction

   // Present one transaction and hold it until the block takes it. Between
   // bursts, drop start for a random gap; some bursts come with no gap at all.
   task automatic send(sdtt_pkg::req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      // busy is read as it stood at the edge, so leaving the loop means accepted
      do @(posedge clock); while (busy);
      case (item.operation)
         sdtt_pkg::OP_INSERT: n_insert++;
         sdtt_pkg::OP_LIST:   n_list++;
         sdtt_pkg::OP_CLEAR:  n_clear++;
         default:             n_unused++;
      endcase
      if (item.operation != OP_UNUSED) counted++;
   endtask

   // Hold off the sender until every expected response has come back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int seg;
      int seg_len;
      int pick;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      n_insert   = 0;
      n_list     = 0;
      n_clear    = 0;
      n_unused   = 0;
      counted    = 0;
      burst_left = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, refused dates, key extremes, ties, ignored code.
      send(make_req(sdtt_pkg::OP_LIST,   4'd0,  6'd0,  5'd0,  6'd0,  32'h0));
      send(make_req(sdtt_pkg::OP_CLEAR,  4'd0,  6'd0,  5'd0,  6'd0,  32'h0));
      send(make_req(OP_UNUSED,           4'd15, 6'd63, 5'd31, 6'd63, 32'hFFFF_FFFF));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd0,  6'd5,  5'd3,  6'd4,  32'h1111_0001));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd13, 6'd5,  5'd3,  6'd4,  32'h1111_0002));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd15, 6'd63, 5'd31, 6'd63, 32'h1111_0003));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd5,  6'd0,  5'd3,  6'd4,  32'h1111_0004));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd5,  6'd32, 5'd3,  6'd4,  32'h1111_0005));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd12, 6'd31, 5'd31, 6'd63, 32'hFFFF_FFFF));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd1,  6'd1,  5'd0,  6'd0,  32'h0000_0000));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd6,  6'd15, 5'd12, 6'd30, 32'hAAAA_0001));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd6,  6'd15, 5'd12, 6'd30, 32'hAAAA_0002));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd6,  6'd15, 5'd12, 6'd30, 32'hAAAA_0003));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd6,  6'd15, 5'd12, 6'd29, 32'h5555_0004));
      send(make_req(sdtt_pkg::OP_LIST,   4'd0,  6'd0,  5'd0,  6'd0,  32'h0));
      send(make_req(OP_UNUSED,           4'd3,  6'd3,  5'd3,  6'd3,  32'h3));
      send(make_req(sdtt_pkg::OP_CLEAR,  4'd0,  6'd0,  5'd0,  6'd0,  32'h0));
      send(make_req(sdtt_pkg::OP_LIST,   4'd0,  6'd0,  5'd0,  6'd0,  32'h0));
      send(make_req(sdtt_pkg::OP_INSERT, 4'd12, 6'd31, 5'd31, 6'd63, 32'h0F0F_0F0F));
      send(make_req(sdtt_pkg::OP_LIST,   4'd0,  6'd0,  5'd0,  6'd0,  32'h0));
      send(make_req(sdtt_pkg::OP_CLEAR,  4'd0,  6'd0,  5'd0,  6'd0,  32'h0));
      drain();

      // Random: segments of mostly valid inserts with refused dates, listings and
      // ignored codes mixed in, each closed by a listing and usually a clear. The
      // first segment overfills the table so that inserts are refused as full.
      seg = 0;
      while (counted < ITEM_TARGET) begin
         seg_len = (seg == 0) ? TABLE_ENTRIES + 4 : $urandom_range(0, 40);
         repeat (seg_len) begin
            pick = $urandom_range(0, 99);
            if (seg == 0 || pick >= 14) send(good_insert());
            else if (pick < 8)          send(bad_insert());
            else if (pick < 12)         send(noise_req(sdtt_pkg::OP_LIST));
            else                        send(noise_req(OP_UNUSED));
         end
         send(noise_req(sdtt_pkg::OP_LIST));
         if ($urandom_range(0, 3) != 0)
            send(noise_req(sdtt_pkg::OP_CLEAR));
         if (seg == 2) drain();
         seg++;
      end

      // Wind down: release start, collect the stragglers, allow a full
      // insert walk for anything the ignored code might still be doing.
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (TABLE_ENTRIES + 8) @(negedge clock);

      $display("Covered %0d transactions: %0d inserts, %0d listings, %0d clears, %0d ignored.",
               n_insert + n_list + n_clear + n_unused, n_insert, n_list, n_clear, n_unused);
      $display("Checked %0d responses field by field; %0d disagreed, %0d never arrived.",
               results_seen, mismatches, outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("sorted_date_time_table_unit regression: pass");
      end else begin
         $display("sorted_date_time_table_unit regression: fail");
      end
      $finish;
   end

endmodule
